[sv/trm_pkg.sv]
// trm_pkg: shared types, constants and codes for the topology range match block
// no dependencies; compiled first
package trm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FRAME_BITS  = 24;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [1:0]            func_t;

  localparam func_t FUNC_BEGIN = 2'd0;
  localparam func_t FUNC_CODE  = 2'd1;
  localparam func_t FUNC_QUERY = 2'd2;

  localparam cnt_t TABLE_FULL = cnt_t'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    SRCH_IDLE,
    SRCH_LAST,
    SRCH_FIRST,
    SRCH_CHECK,
    SRCH_STEP,
    SRCH_END,
    SRCH_EMIT
  } srch_state_t;

  // query handed from the top level to the search sequencer
  typedef struct packed {
    logic   start;
    frame_t frame_a;
    frame_t frame_b;
    cnt_t   count;
  } srch_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic match;
  } srch_rsp_t;

endpackage

[sv/trm_if.sv]
// trm_in_if and trm_out_if: valid/ready channels of the topology range match block
// depends on trm_pkg
interface trm_in_if;
  logic            valid;
  logic            ready;
  trm_pkg::func_t  func;
  logic            same_as_previous;
  trm_pkg::frame_t frame_a;
  trm_pkg::frame_t frame_b;

  modport source (output valid, func, same_as_previous, frame_a, frame_b, input ready);
  modport sink   (input valid, func, same_as_previous, frame_a, frame_b, output ready);
endinterface

interface trm_out_if;
  logic valid;
  logic ready;
  logic same_topology;
  logic table_overflowed;

  modport source (output valid, same_topology, table_overflowed, input ready);
  modport sink   (input valid, same_topology, table_overflowed, output ready);
endinterface

[sv/trm_table.sv]
// trm_table: change-point memory, one write port and one read port with registered data
// depends on trm_pkg
module trm_table (
  input  logic            clk,
  input  logic            wr_en,
  input  trm_pkg::idx_t   wr_addr,
  input  trm_pkg::frame_t wr_data,
  input  trm_pkg::idx_t   rd_addr,
  output trm_pkg::frame_t rd_data
);
  import trm_pkg::*;

  frame_t mem [TABLE_DEPTH];
  frame_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/trm_search.sv]
// trm_search: sequencer and shared compare unit for the floored-interval binary search
// depends on trm_pkg; reads the table through trm_table's registered read port
module trm_search (
  input  logic               clk,
  input  logic               rst_n,
  input  trm_pkg::srch_req_t req,
  input  logic               out_free,
  output trm_pkg::srch_rsp_t rsp,
  output trm_pkg::idx_t      rd_addr,
  input  trm_pkg::frame_t    rd_data
);
  import trm_pkg::*;

  srch_state_t state_r, state_nxt;
  frame_t      a_r, a_nxt;
  frame_t      b_r, b_nxt;
  cnt_t        cnt_r, cnt_nxt;
  frame_t      last_r, last_nxt;
  frame_t      lo_val_r, lo_val_nxt;
  idx_t        lo_r, lo_nxt;
  idx_t        hi_r, hi_nxt;
  idx_t        mid_r, mid_nxt;
  logic        match_r, match_nxt;

  logic              probe;
  idx_t              lo_n, hi_n;
  idx_t              last_idx;
  logic [IDX_BITS:0] mid_sum;

  assign last_idx = idx_t'(cnt_r - cnt_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SRCH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    lo_val_r <= lo_val_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    match_r  <= match_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    lo_val_nxt = lo_val_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    match_nxt  = match_r;
    rd_addr    = '0;
    probe      = 1'b0;
    lo_n       = lo_r;
    hi_n       = hi_r;
    rsp.done   = 1'b0;
    rsp.busy   = (state_r != SRCH_IDLE);
    rsp.match  = match_r;

    case (state_r)
      SRCH_IDLE: begin
        if (req.start) begin
          a_nxt   = req.frame_a;
          b_nxt   = req.frame_b;
          cnt_nxt = req.count;
          if (req.count == '0) begin
            match_nxt = 1'b1;
            state_nxt = SRCH_EMIT;
          end else begin
            state_nxt = SRCH_LAST;
          end
        end
      end
      SRCH_LAST: begin
        rd_addr   = last_idx;
        state_nxt = SRCH_FIRST;
      end
      SRCH_FIRST: begin
        last_nxt  = rd_data;
        rd_addr   = '0;
        state_nxt = SRCH_CHECK;
      end
      SRCH_CHECK: begin
        // rd_data holds the first entry here
        if (a_r >= last_r) begin
          match_nxt = (b_r >= last_r);
          state_nxt = SRCH_EMIT;
        end else if (a_r < rd_data) begin
          match_nxt = (b_r < rd_data);
          state_nxt = SRCH_EMIT;
        end else begin
          lo_val_nxt = rd_data;
          lo_n       = '0;
          hi_n       = last_idx;
          probe      = 1'b1;
        end
      end
      SRCH_STEP: begin
        // rd_data holds the entry at mid
        if (a_r < rd_data) begin
          hi_n = mid_r - idx_t'(1);
        end else begin
          lo_n       = mid_r;
          lo_val_nxt = rd_data;
        end
        probe = 1'b1;
      end
      SRCH_END: begin
        match_nxt = (b_r >= lo_val_r) && (b_r < rd_data);
        state_nxt = SRCH_EMIT;
      end
      SRCH_EMIT: begin
        if (out_free) begin
          rsp.done  = 1'b1;
          state_nxt = SRCH_IDLE;
        end
      end
      default: begin
        state_nxt = SRCH_IDLE;
      end
    endcase

    // issue the next probe, or the entry just above the final interval
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n} + {{IDX_BITS{1'b0}}, 1'b1};
    if (probe) begin
      lo_nxt = lo_n;
      hi_nxt = hi_n;
      if (hi_n > lo_n) begin
        mid_nxt   = mid_sum[IDX_BITS:1];
        rd_addr   = mid_sum[IDX_BITS:1];
        state_nxt = SRCH_STEP;
      end else begin
        rd_addr   = lo_n + idx_t'(1);
        state_nxt = SRCH_END;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (state_r == SRCH_IDLE))
    else $error("search started while busy");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (out_free && state_r == SRCH_EMIT))
    else $error("result released while output slot busy");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SRCH_STEP) |-> (hi_r >= mid_r && mid_r > lo_r))
    else $error("probe index outside search window");

  a_end_below_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SRCH_END) |-> ({1'b0, lo_r} < (cnt_r - cnt_t'(1))))
    else $error("final interval at or above last entry");

endmodule

[sv/topology_range_match_top.sv]
// topology_range_match_top: frame counter, change-point bookkeeping and result register
// depends on trm_pkg, trm_if, trm_table and trm_search
//
// usage:
//   in_if carries one item per valid/ready handshake: func selects begin coding,
//   code one frame (same_as_previous) or query (frame_a, frame_b)
//   out_if returns one item per query: same_topology and the sticky
//   table_overflowed flag; begin, code and unused func codes return nothing
//   begin and code items can follow back to back
//   a query holds in_if.ready low while the search runs on the single table
//   read port: an empty table goes straight to the result; otherwise the last
//   and first entries are read, and a binary search between them follows only
//   when frame_a falls at or above the first entry and below the last;
//   in_if.ready rises with the edge that registers the result
//   one result register decouples the sides: the next item is accepted while a
//   result waits, and a second query waits in its last state until out_if.ready
//   reset: entry count 0, frame counter all ones, overflow flag clear, no
//   result pending; the table itself is not cleared, only entries below the
//   count are ever read
module topology_range_match_top (
  input  logic             clk,
  input  logic             rst_n,
  trm_in_if.sink           in_if,
  trm_out_if.source        out_if
);
  import trm_pkg::*;

  frame_t    counter_r, counter_nxt;
  cnt_t      count_r, count_nxt;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_same_r, out_same_nxt;
  logic      out_ovf_r, out_ovf_nxt;

  logic      in_accept;
  logic      out_free;
  logic      wr_en;
  frame_t    counter_inc;
  srch_req_t req;
  srch_rsp_t rsp;
  idx_t      rd_addr;
  frame_t    rd_data;

  assign in_if.ready = !rsp.busy;
  assign in_accept   = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign counter_inc = counter_r + frame_t'(1);

  always_comb begin
    counter_nxt = counter_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    wr_en       = 1'b0;
    req.start   = 1'b0;
    req.frame_a = in_if.frame_a;
    req.frame_b = in_if.frame_b;
    req.count   = count_r;
    if (in_accept) begin
      case (in_if.func)
        FUNC_BEGIN: begin
          counter_nxt = '1;
        end
        FUNC_CODE: begin
          counter_nxt = counter_inc;
          if (!in_if.same_as_previous) begin
            if (count_r < TABLE_FULL) begin
              wr_en     = 1'b1;
              count_nxt = count_r + cnt_t'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        FUNC_QUERY: begin
          req.start = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_same_nxt  = out_same_r;
    out_ovf_nxt   = out_ovf_r;
    if (rsp.done) begin
      out_valid_nxt = 1'b1;
      out_same_nxt  = rsp.match;
      out_ovf_nxt   = ovf_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r   <= '1;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      counter_r   <= counter_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_same_r <= out_same_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  trm_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_BITS-1:0]),
    .wr_data (counter_inc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trm_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .out_free (out_free),
    .rsp      (rsp),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  assign out_if.valid            = out_valid_r;
  assign out_if.same_topology    = out_same_r;
  assign out_if.table_overflowed = out_ovf_r;

endmodule
